@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/ces_pkg.sv @@
// Package: widths, stage payload types and calendar tables for the epoch converter.
`default_nettype none

package ces_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int Q100_W   = 8;
   localparam int MDAYS_W  = 9;
   localparam int DAYS_W   = 23;
   localparam int HOURS_W  = 27;
   localparam int MINS_W   = 33;
   localparam int SECS_W   = 38;
   localparam int PROD_W   = 27;

   localparam int EPOCH_YEAR = 1970;
   localparam int DAY_OFFSET = 719499;
   // floor(y * RECIP_100 / 2^RECIP_SHIFT) == floor(y / 100) for all 14-bit y
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [YEAR_W-1:0]   yadj;
      logic [MONTH_W-1:0]  madj;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic                base_ok;
      logic                is_feb;
      logic [DAY_W-1:0]    mlen;
   } front_type;

   typedef struct packed {
      front_type           f;
      logic [Q100_W-1:0]   q_year;
      logic [Q100_W-1:0]   q_adj;
   } recip_type;

   typedef struct packed {
      logic                ok;
      logic [DAYS_W-1:0]   days;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } days_type;

   // Days in month, February taken as 28; zero for codes that are no month.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // floor(367 * m / 12) for the March-based month number.
   function automatic logic [MDAYS_W-1:0] month_days(input logic [MONTH_W-1:0] m);
      logic [MDAYS_W-1:0] d;
      case (m)
         4'd1:    d = 9'd30;
         4'd2:    d = 9'd61;
         4'd3:    d = 9'd91;
         4'd4:    d = 9'd122;
         4'd5:    d = 9'd152;
         4'd6:    d = 9'd183;
         4'd7:    d = 9'd214;
         4'd8:    d = 9'd244;
         4'd9:    d = 9'd275;
         4'd10:   d = 9'd305;
         4'd11:   d = 9'd336;
         4'd12:   d = 9'd367;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ces_front.sv @@
// Front stages: field range checks, month shift, then divide-by-100 of the years.
`default_nettype none

module ces_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   output logic                                  in_ready,
   input  wire logic [ces_pkg::YEAR_W-1:0]       in_year,
   input  wire logic [ces_pkg::MONTH_W-1:0]      in_month,
   input  wire logic [ces_pkg::DAY_W-1:0]        in_day,
   input  wire logic [ces_pkg::HOUR_W-1:0]       in_hour,
   input  wire logic [ces_pkg::MINUTE_W-1:0]     in_minute,
   input  wire logic [ces_pkg::SECOND_W-1:0]     in_second,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output ces_pkg::recip_type                    out_data
);

   logic                 a_valid_ff;
   ces_pkg::front_type   a_ff, a_in;
   logic                 a_ready;
   logic                 b_valid_ff;
   ces_pkg::recip_type   b_ff, b_in;
   logic                 b_ready;
   logic [ces_pkg::PROD_W-1:0] prod_year, prod_adj;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      a_in.year   = in_year;
      a_in.day    = in_day;
      a_in.hour   = in_hour;
      a_in.minute = in_minute;
      a_in.second = in_second;
      a_in.is_feb = (in_month == 4'd2);
      a_in.mlen   = ces_pkg::month_len(in_month);
      // Jan and Feb count as months 11 and 12 of the previous year
      if (in_month <= 4'd2) begin
         a_in.yadj = in_year - 14'd1;
         a_in.madj = in_month + 4'd10;
      end else begin
         a_in.yadj = in_year;
         a_in.madj = in_month - 4'd2;
      end
      a_in.base_ok = (in_year >= ces_pkg::YEAR_W'(ces_pkg::EPOCH_YEAR))
                  && (in_month >= 4'd1) && (in_month <= 4'd12)
                  && (in_day >= 5'd1)
                  && (in_hour <= 5'd23) && (in_minute <= 6'd59)
                  && (in_second <= 6'd60);
   end

   always_comb begin
      prod_year = ces_pkg::PROD_W'(a_ff.year) * ces_pkg::PROD_W'(ces_pkg::RECIP_100);
      prod_adj  = ces_pkg::PROD_W'(a_ff.yadj) * ces_pkg::PROD_W'(ces_pkg::RECIP_100);
      b_in.f      = a_ff;
      b_in.q_year = ces_pkg::Q100_W'(prod_year >> ces_pkg::RECIP_SHIFT);
      b_in.q_adj  = ces_pkg::Q100_W'(prod_adj >> ces_pkg::RECIP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) a_ff <= a_in;
      if (b_ready && a_valid_ff) b_ff <= b_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_ff;

endmodule

`default_nettype wire

@@ rtl/ces_days.sv @@
// Day-count stage: leap-year test, day range check and days since the epoch.
`default_nettype none

module ces_days (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire ces_pkg::recip_type  in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output ces_pkg::days_type        out_data
);

   logic                          c_valid_ff;
   ces_pkg::days_type             c_ff, c_in;
   logic                          leap;
   logic [ces_pkg::DAY_W-1:0]     max_day;
   logic [ces_pkg::YEAR_W-1:0]    cent_year;
   logic [ces_pkg::DAYS_W-1:0]    yd;

   assign in_ready = !c_valid_ff || out_ready;

   always_comb begin
      cent_year = ces_pkg::YEAR_W'(in_data.q_year) * ces_pkg::YEAR_W'(100);
      // divisible by 4, and not a century unless the century is divisible by 4
      leap = (in_data.f.year[1:0] == 2'd0)
          && ((in_data.f.year != cent_year) || (in_data.q_year[1:0] == 2'd0));
      max_day = (in_data.f.is_feb && leap) ? 5'd29 : in_data.f.mlen;
      yd = ces_pkg::DAYS_W'(in_data.f.yadj);

      c_in.ok     = in_data.f.base_ok && (in_data.f.day <= max_day);
      c_in.hour   = in_data.f.hour;
      c_in.minute = in_data.f.minute;
      c_in.second = in_data.f.second;
      c_in.days   = (yd >> 2)
                  - ces_pkg::DAYS_W'(in_data.q_adj)
                  + ces_pkg::DAYS_W'(in_data.q_adj >> 2)
                  + ces_pkg::DAYS_W'(ces_pkg::month_days(in_data.f.madj))
                  + ces_pkg::DAYS_W'(in_data.f.day)
                  + yd * ces_pkg::DAYS_W'(365)
                  - ces_pkg::DAYS_W'(ces_pkg::DAY_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (in_ready) begin
         c_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) c_ff <= c_in;
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_ff;

endmodule

`default_nettype wire

@@ rtl/ces_scale.sv @@
// Scaling stages: days to hours, minutes and seconds, one multiply per stage.
`default_nettype none

module ces_scale (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire ces_pkg::days_type             in_data,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic                               out_ok,
   output logic [ces_pkg::SECS_W-1:0]         out_seconds
);

   logic                            d_valid_ff, e_valid_ff, f_valid_ff;
   logic                            d_ready, e_ready, f_ready;
   logic                            d_ok_ff, e_ok_ff, f_ok_ff;
   logic [ces_pkg::HOURS_W-1:0]     d_hours_ff, d_hours_in;
   logic [ces_pkg::MINUTE_W-1:0]    d_minute_ff;
   logic [ces_pkg::SECOND_W-1:0]    d_second_ff, e_second_ff;
   logic [ces_pkg::MINS_W-1:0]      e_mins_ff, e_mins_in;
   logic [ces_pkg::SECS_W-1:0]      f_secs_ff, f_secs_in;

   assign f_ready  = !f_valid_ff || out_ready;
   assign e_ready  = !e_valid_ff || f_ready;
   assign d_ready  = !d_valid_ff || e_ready;
   assign in_ready = d_ready;

   assign d_hours_in = ces_pkg::HOURS_W'(in_data.days) * ces_pkg::HOURS_W'(24)
                     + ces_pkg::HOURS_W'(in_data.hour);
   assign e_mins_in  = ces_pkg::MINS_W'(d_hours_ff) * ces_pkg::MINS_W'(60)
                     + ces_pkg::MINS_W'(d_minute_ff);
   // wraps modulo 2^38 for the latest years within the 14-bit field range
   assign f_secs_in  = e_ok_ff
                     ? ces_pkg::SECS_W'(e_mins_ff) * ces_pkg::SECS_W'(60)
                       + ces_pkg::SECS_W'(e_second_ff)
                     : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         if (d_ready) d_valid_ff <= in_valid;
         if (e_ready) e_valid_ff <= d_valid_ff;
         if (f_ready) f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (d_ready && in_valid) begin
         d_ok_ff     <= in_data.ok;
         d_hours_ff  <= d_hours_in;
         d_minute_ff <= in_data.minute;
         d_second_ff <= in_data.second;
      end
      if (e_ready && d_valid_ff) begin
         e_ok_ff     <= d_ok_ff;
         e_mins_ff   <= e_mins_in;
         e_second_ff <= d_second_ff;
      end
      if (f_ready && e_valid_ff) begin
         f_ok_ff   <= e_ok_ff;
         f_secs_ff <= f_secs_in;
      end
   end

   assign out_valid   = f_valid_ff;
   assign out_ok      = f_ok_ff;
   assign out_seconds = f_secs_ff;

endmodule

`default_nettype wire

@@ rtl/civil_date_to_epoch_seconds.sv @@
// Top level: Gregorian UTC date and time to seconds since 1970-01-01.
// Throughput: one word per cycle when not stalled by rsp_ready; each of the six
// stages holds one word. The six register stages are: checks, divide by 100,
// day sum, then the hour, minute and second multiplies.
// Reset clears the stage valid bits only; payload registers are not reset.
`default_nettype none

`include "assert_macros.svh"

module civil_date_to_epoch_seconds (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ces_pkg::YEAR_W-1:0]    req_year,
   input  wire logic [ces_pkg::MONTH_W-1:0]   req_month,
   input  wire logic [ces_pkg::DAY_W-1:0]     req_day,
   input  wire logic [ces_pkg::HOUR_W-1:0]    req_hour,
   input  wire logic [ces_pkg::MINUTE_W-1:0]  req_minute,
   input  wire logic [ces_pkg::SECOND_W-1:0]  req_second,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid_res,
   output logic [ces_pkg::SECS_W-1:0]         rsp_epoch_seconds
);

   logic                 front_valid, front_ready;
   ces_pkg::recip_type   front_data;
   logic                 days_valid, days_ready;
   ces_pkg::days_type    days_data;

   ces_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_year   (req_year),
      .in_month  (req_month),
      .in_day    (req_day),
      .in_hour   (req_hour),
      .in_minute (req_minute),
      .in_second (req_second),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   ces_days u_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (days_valid),
      .out_ready (days_ready),
      .out_data  (days_data)
   );

   ces_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (days_valid),
      .in_ready    (days_ready),
      .in_data     (days_data),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_ok      (rsp_valid_res),
      .out_seconds (rsp_epoch_seconds)
   );

   // a rejected date always reports zero seconds
   `ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_valid && !rsp_valid_res, rsp_epoch_seconds == '0, "rejected date with nonzero seconds")
   // an empty output stage means the whole pipe can move
   `ASSERT_IMPLY(a_empty_ready, clock, reset, !rsp_valid, req_ready, "input stalled with empty output stage")
   // downstream ready propagates through every stage
   `ASSERT_IMPLY(a_ready_chain, clock, reset, rsp_ready, req_ready, "input stalled while output drains")

endmodule

`default_nettype wire

@@ bench/civil_date_to_epoch_seconds_tb.sv @@
// Testbench for the date to epoch seconds converter: directed table, then random dates.
`timescale 1ns / 100ps

module civil_date_to_epoch_seconds_tb;

   localparam int FIRST_YEAR   = 1970;
   localparam int DAY_BIAS     = 719499;
   localparam int RANDOM_WORDS = 600;
   localparam int MAX_LINES    = 100;

   typedef struct packed {
      logic [ces_pkg::YEAR_W-1:0]   year;
      logic [ces_pkg::MONTH_W-1:0]  month;
      logic [ces_pkg::DAY_W-1:0]    day;
      logic [ces_pkg::HOUR_W-1:0]   hour;
      logic [ces_pkg::MINUTE_W-1:0] minute;
      logic [ces_pkg::SECOND_W-1:0] second;
   } date_type;

   typedef struct packed {
      logic                       valid_res;
      logic [ces_pkg::SECS_W-1:0] seconds;
   } epoch_type;

   typedef struct packed {
      date_type  date;
      logic      typed;
      epoch_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [ces_pkg::YEAR_W-1:0]   req_year;
   logic [ces_pkg::MONTH_W-1:0]  req_month;
   logic [ces_pkg::DAY_W-1:0]    req_day;
   logic [ces_pkg::HOUR_W-1:0]   req_hour;
   logic [ces_pkg::MINUTE_W-1:0] req_minute;
   logic [ces_pkg::SECOND_W-1:0] req_second;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_valid_res;
   logic [ces_pkg::SECS_W-1:0] rsp_epoch_seconds;

   epoch_type epoch_due [$];
   row_type   date_rows [$];
   epoch_type got_want;
   int     mismatch_count = 0;
   int     words_sent = 0;
   logic   hold_done = 1'b0;
   wire    calm = (words_sent >= 150) && (words_sent < 300);

   civil_date_to_epoch_seconds dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_year          (req_year),
      .req_month         (req_month),
      .req_day           (req_day),
      .req_hour          (req_hour),
      .req_minute        (req_minute),
      .req_second        (req_second),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_valid_res     (rsp_valid_res),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      if (mismatch_count < MAX_LINES) begin
         $display("mismatch @%0t: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   function automatic logic [4:0] month_span(input logic [13:0] y, input logic [3:0] m);
      logic leap;
      logic [4:0] len;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic epoch_type predict_epoch(input date_type d);
      logic [63:0] y, m, days, secs;
      logic ok;
      epoch_type r;
      ok = (d.year >= FIRST_YEAR) && (d.month >= 1) && (d.month <= 12) && (d.day >= 1)
         && (d.day <= month_span(d.year, d.month)) && (d.hour <= 23)
         && (d.minute <= 59) && (d.second <= 60);
      r = '0;
      if (ok) begin
         // March-based year: Jan and Feb belong to the year before
         if (d.month <= 2) begin
            m = 64'(d.month) + 10;
            y = 64'(d.year) - 1;
         end else begin
            m = 64'(d.month) - 2;
            y = 64'(d.year);
         end
         days = y / 4 - y / 100 + y / 400 + (367 * m) / 12 + 64'(d.day) + 365 * y - DAY_BIAS;
         secs = ((days * 24 + 64'(d.hour)) * 60 + 64'(d.minute)) * 60 + 64'(d.second);
         r.valid_res = 1'b1;
         r.seconds   = secs[ces_pkg::SECS_W-1:0];
      end
      return r;
   endfunction

   function automatic date_type make_date();
      date_type d;
      int pick;
      logic [4:0] len;
      pick = $urandom_range(0, 9);
      if (pick <= 5) d.year = 14'($urandom_range(FIRST_YEAR, 2100));
      else if (pick <= 8) d.year = 14'($urandom_range(FIRST_YEAR, 9999));
      else d.year = 14'($urandom_range(10000, 16383));
      d.month = 4'($urandom_range(1, 12));
      len = month_span(d.year, d.month);
      d.day = ($urandom_range(0, 3) == 0) ? len : 5'($urandom_range(1, len));
      d.hour = 5'($urandom_range(0, 23));
      d.minute = 6'($urandom_range(0, 59));
      d.second = ($urandom_range(0, 19) == 0) ? 6'd60 : 6'($urandom_range(0, 59));
      pick = $urandom_range(0, 99);
      if (pick >= 85) begin
         // raw noise across the full field widths
         d.year = 14'($urandom_range(0, 16383));
         d.month = 4'($urandom);
         d.day = 5'($urandom);
         d.hour = 5'($urandom);
         d.minute = 6'($urandom);
         d.second = 6'($urandom);
      end else if (pick >= 70) begin
         // well-formed date with one field knocked out of range
         case ($urandom_range(0, 5))
            0: d.year = 14'($urandom_range(0, FIRST_YEAR - 1));
            1: d.month = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
            2: d.day = (len == 31 || $urandom_range(0, 1) == 0) ? 5'd0 : len + 5'd1;
            3: d.hour = 5'($urandom_range(24, 31));
            4: d.minute = 6'($urandom_range(60, 63));
            default: d.second = 6'($urandom_range(61, 63));
         endcase
      end
      return d;
   endfunction

   task automatic add_row(input int y, input int mo, input int dd, input int h, input int mi,
                          input int s, input logic typed, input logic v, input longint secs);
      row_type r;
      r.date = '{year: 14'(y), month: 4'(mo), day: 5'(dd), hour: 5'(h), minute: 6'(mi),
                 second: 6'(s)};
      r.typed = typed;
      r.want = '{valid_res: v, seconds: 38'(secs)};
      date_rows.push_back(r);
   endtask

   task automatic offer(input date_type d, input logic typed, input epoch_type want);
      while (!calm && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_year   <= d.year;
      req_month  <= d.month;
      req_day    <= d.day;
      req_hour   <= d.hour;
      req_minute <= d.minute;
      req_second <= d.second;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      epoch_due.push_back(typed ? want : predict_epoch(d));
      words_sent++;
   endtask

   initial begin : stim_proc
      int drain;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_year   <= '0;
      req_month  <= '0;
      req_day    <= '0;
      req_hour   <= '0;
      req_minute <= '0;
      req_second <= '0;

      add_row(1970, 1, 1, 0, 0, 0, 1, 1, 0);
      add_row(1970, 1, 1, 0, 0, 1, 1, 1, 1);
      add_row(1970, 1, 2, 0, 0, 0, 1, 1, 86400);
      add_row(1970, 1, 1, 23, 59, 60, 1, 1, 86400);  // leap second rolls to next day
      add_row(1970, 12, 31, 23, 59, 59, 1, 1, 31535999);
      add_row(1969, 12, 31, 23, 59, 59, 1, 0, 0);
      add_row(0, 0, 0, 0, 0, 0, 1, 0, 0);
      add_row(16383, 15, 31, 31, 63, 63, 1, 0, 0);
      add_row(2000, 0, 1, 0, 0, 0, 1, 0, 0);
      add_row(2000, 13, 1, 0, 0, 0, 1, 0, 0);
      add_row(2000, 15, 1, 0, 0, 0, 1, 0, 0);
      add_row(2000, 1, 0, 0, 0, 0, 1, 0, 0);
      add_row(2001, 4, 31, 0, 0, 0, 1, 0, 0);
      add_row(2100, 2, 29, 0, 0, 0, 1, 0, 0);
      add_row(2024, 2, 30, 0, 0, 0, 1, 0, 0);
      add_row(2000, 6, 1, 24, 0, 0, 1, 0, 0);
      add_row(2000, 6, 1, 0, 60, 0, 1, 0, 0);
      add_row(2000, 6, 1, 0, 0, 61, 1, 0, 0);
      add_row(2000, 2, 29, 12, 30, 30, 0, 0, 0);
      add_row(2024, 2, 29, 0, 0, 0, 0, 0, 0);
      add_row(2000, 3, 1, 0, 0, 0, 0, 0, 0);
      add_row(2016, 12, 31, 23, 59, 60, 0, 0, 0);
      add_row(9999, 12, 31, 23, 59, 60, 0, 0, 0);
      add_row(16383, 12, 31, 23, 59, 59, 0, 0, 0);  // past 2^38, wraps

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (date_rows[i]) offer(date_rows[i].date, date_rows[i].typed, date_rows[i].want);
      for (int i = 0; i < RANDOM_WORDS; i++) offer(make_date(), 1'b0, '0);
      req_valid <= 1'b0;

      drain = 0;
      while (epoch_due.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (12) @(posedge clock);
      if (epoch_due.size() != 0) begin
         flag_mismatch($sformatf("%0d result words never arrived", epoch_due.size()));
      end

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // receiver: random stalls outside the calm window, one long hold-off so the pipe backs up
   initial begin : sink_proc
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && words_sent >= 400) begin
            rsp_ready <= 1'b0;
            for (int n = 0; n < 200; n++) @(posedge clock);
            hold_done = 1'b1;
         end
         if (calm) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 99) >= 20);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (epoch_due.size() == 0) begin
            flag_mismatch("result word with nothing expected");
         end else begin
            got_want = epoch_due.pop_front();
            if (rsp_valid_res !== got_want.valid_res) begin
               flag_mismatch($sformatf("valid_res got %0b want %0b",
                                       rsp_valid_res, got_want.valid_res));
            end
            if (rsp_epoch_seconds !== got_want.seconds) begin
               flag_mismatch($sformatf("epoch_seconds got %0d want %0d",
                                       rsp_epoch_seconds, got_want.seconds));
            end
         end
      end
   end

   initial begin : watchdog
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule
